// ===== hw/rtl/sfpk_pkg.sv =====
// Shared types and constants for the shelf next-fit rectangle packer.
// Depends on nothing; the interfaces and the top level import it.
`default_nettype none

package sfpk_pkg;

    // Width of every coordinate field on the channels and the config port
    localparam int FIELD_W = 16;

    // Default coordinate range of the atlas height
    localparam int COORD_BITS_DEF = 16;

    // Register reset values
    localparam logic [FIELD_W-1:0] ATLAS_WIDTH_RST = 16'd1024;
    localparam logic [FIELD_W-1:0] INIT_HEIGHT_RST = 16'd1024;

    typedef enum logic [1:0] {
        CFG_ATLAS_WIDTH = 2'd0,
        CFG_INIT_HEIGHT = 2'd1,
        CFG_ALLOW_ROT   = 2'd2,
        CFG_ALLOW_GROW  = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,   // wait for a rectangle beat
        ST_SORT,   // order the sides: short side across, long side up
        ST_R1A,    // upright on current shelf: does the shelf height cover it
        ST_R1B,    // upright on current shelf: is there width left
        ST_R2A,    // lying on current shelf: is there width left
        ST_R2B,    // lying on current shelf: is there height left
        ST_ROPEN,  // rotation failed on the shelf: close it
        ST_RPICK,  // choose orientation for the new shelf
        ST_U1,     // does the rectangle fit the remaining shelf width
        ST_UOPEN,  // close the shelf and open a new one
        ST_UFIT,   // is the rectangle wider than the atlas
        ST_UNEED,  // does the atlas have the height
        ST_GROW,   // double the atlas height, one step a cycle
        ST_PUT1,   // record position, advance shelf fill
        ST_PUT2,   // raise shelf height
        ST_FIN     // hand the result to the output register
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/sfpk_rect_if.sv =====
// Rectangle channel: one beat carries the size of one rectangle.
// Depends on sfpk_pkg for the field width.
`default_nettype none

interface sfpk_rect_if;
    import sfpk_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] rect_width;
    logic [FIELD_W-1:0] rect_height;

    modport source (output valid, output rect_width, output rect_height, input ready);
    modport sink   (input valid, input rect_width, input rect_height, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sfpk_place_if.sv =====
// Placement channel: one beat carries the result for one rectangle.
// Depends on sfpk_pkg for the field width.
`default_nettype none

interface sfpk_place_if;
    import sfpk_pkg::*;

    logic               valid;
    logic               ready;
    logic               placed;
    logic [FIELD_W-1:0] pos_x;
    logic [FIELD_W-1:0] pos_y;
    logic [FIELD_W-1:0] stored_width;
    logic [FIELD_W-1:0] stored_height;
    logic [FIELD_W-1:0] atlas_height;

    modport source (
        output valid, output placed, output pos_x, output pos_y,
        output stored_width, output stored_height, output atlas_height,
        input ready
    );
    modport sink (
        input valid, input placed, input pos_x, input pos_y,
        input stored_width, input stored_height, input atlas_height,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/sfpk_addcmp.sv =====
// Shared add-and-compare unit of the packer: sum = a + b, le = (sum <= c).
// Depends on nothing; the sequencer in the top level drives its operands.
`default_nettype none

module sfpk_addcmp #(
    parameter int W = 17
) (
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    input  wire logic [W-1:0] i_c,
    output logic      [W:0]   o_sum,
    output logic              o_le
);
    assign o_sum = {1'b0, i_a} + {1'b0, i_b};
    assign o_le  = (o_sum <= {1'b0, i_c});
endmodule

`default_nettype wire

// ===== hw/rtl/shelf_next_fit_rect_packer_top.sv =====
// Shelf next-fit rectangle packer, top level. Uses sfpk_pkg, sfpk_rect_if,
// sfpk_place_if and the shared add/compare unit sfpk_addcmp.
`default_nettype none

// Each rectangle beat is placed into an atlas of fixed width by shelf
// next-fit and yields exactly one placement beat (placed flag, position,
// size as stored and the atlas height after any growth). One item is worked
// at a time: i_rect.ready is high only while the sequencer is idle. All
// additions and comparisons go through a single add/compare unit, at most
// one use per cycle and per sequencer step. Without rotation a placed
// item passes the fill check, the height check and the two placement
// steps; opening a new shelf adds the close step and the check against the
// atlas width. With rotation the sides are sorted first, and the upright
// and the lying fit on the current shelf are tried before a new shelf is
// opened and its orientation chosen. A rejected item ends sooner. Growth
// adds a step for each doubling of the atlas height plus a final check.
// The output register lets the next rectangle be accepted while a result
// still waits on o_place.ready; a finished item holds in the last step until
// that register is free.
// Atlas width and growth writes also affect an item in progress; rotation
// is read when a beat is accepted. The atlas height starts at its reset
// value after each reset. COORD_BITS bounds how far the height may grow; a
// doubling past its range rejects the item and leaves the height unchanged.

module shelf_next_fit_rect_packer_top #(
    parameter int COORD_BITS = sfpk_pkg::COORD_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire sfpk_pkg::t_cfg_idx            i_cfg_idx,
    input  wire logic [sfpk_pkg::FIELD_W-1:0]  i_cfg_data,
    sfpk_rect_if.sink                          i_rect,
    sfpk_place_if.source                       o_place
);
    import sfpk_pkg::*;

    // Height registers cover the wider of the field range and COORD_BITS
    localparam int HW = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int UW = HW + 1;
    localparam logic [UW-1:0] COORD_MAX =
        {{(UW-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};

    // Configuration
    logic [FIELD_W-1:0] r_atlas_w;
    logic               r_allow_rot;
    logic               r_allow_grow;

    // Packing state
    t_state             r_state, n_state;
    logic [FIELD_W-1:0] r_fill, n_fill;
    logic [FIELD_W-1:0] r_shelf_h, n_shelf_h;
    logic [HW-1:0]      r_closed, n_closed;
    logic [HW-1:0]      r_cah, n_cah;

    // Per-item working registers
    logic [FIELD_W-1:0] r_cw, n_cw;
    logic [FIELD_W-1:0] r_ch, n_ch;
    logic               r_flag, n_flag;
    logic               r_ok, n_ok;
    logic [FIELD_W-1:0] r_rx, n_rx;
    logic [HW-1:0]      r_ry, n_ry;
    logic [UW-1:0]      r_g, n_g;
    logic [UW-1:0]      r_need, n_need;

    // Output register
    logic               r_out_valid;
    logic               r_o_placed;
    logic [FIELD_W-1:0] r_o_x, r_o_y, r_o_w, r_o_h, r_o_ah;
    logic               fin_load;

    // Shared unit operands
    logic [UW-1:0]      u_a, u_b, u_c;
    logic [UW:0]        u_sum;
    logic               u_le;

    sfpk_addcmp #(.W(UW)) u_addcmp (
        .i_a   (u_a),
        .i_b   (u_b),
        .i_c   (u_c),
        .o_sum (u_sum),
        .o_le  (u_le)
    );

    // Config writes; an initial height write is ignored, reset sets INIT_HEIGHT_RST
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas_w    <= ATLAS_WIDTH_RST;
            r_allow_rot  <= 1'b0;
            r_allow_grow <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ATLAS_WIDTH: r_atlas_w    <= i_cfg_data;
                CFG_INIT_HEIGHT: ;
                CFG_ALLOW_ROT:   r_allow_rot  <= i_cfg_data[0];
                CFG_ALLOW_GROW:  r_allow_grow <= i_cfg_data[0];
            endcase
        end
    end

    assign i_rect.ready = (r_state == ST_IDLE);
    assign fin_load     = (r_state == ST_FIN) && (!r_out_valid || o_place.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_shelf_h <= '0;
            r_closed  <= '0;
            r_cah     <= HW'(INIT_HEIGHT_RST);
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_shelf_h <= n_shelf_h;
            r_closed  <= n_closed;
            r_cah     <= n_cah;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cw   <= n_cw;
        r_ch   <= n_ch;
        r_flag <= n_flag;
        r_ok   <= n_ok;
        r_rx   <= n_rx;
        r_ry   <= n_ry;
        r_g    <= n_g;
        r_need <= n_need;
    end

    // Sequencer: at most one use of the add/compare unit per step
    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_shelf_h = r_shelf_h;
        n_closed  = r_closed;
        n_cah     = r_cah;
        n_cw      = r_cw;
        n_ch      = r_ch;
        n_flag    = r_flag;
        n_ok      = r_ok;
        n_rx      = r_rx;
        n_ry      = r_ry;
        n_g       = r_g;
        n_need    = r_need;
        u_a       = '0;
        u_b       = '0;
        u_c       = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_rect.valid) begin
                    n_cw    = i_rect.rect_width;
                    n_ch    = i_rect.rect_height;
                    n_ok    = 1'b0;
                    n_state = r_allow_rot ? ST_SORT : ST_U1;
                end
            end
            ST_SORT: begin
                // height <= width: swap so cw is the short side
                u_a = UW'(r_ch);
                u_c = UW'(r_cw);
                if (u_le) begin
                    n_cw = r_ch;
                    n_ch = r_cw;
                end
                n_state = ST_R1A;
            end
            ST_R1A: begin
                u_a     = UW'(r_ch);
                u_c     = UW'(r_shelf_h);
                n_flag  = u_le;
                n_state = ST_R1B;
            end
            ST_R1B: begin
                u_a = UW'(r_fill);
                u_b = UW'(r_cw);
                u_c = UW'(r_atlas_w);
                if (r_flag && (u_le || r_cw == '0)) begin
                    n_state = ST_PUT1;
                end else begin
                    n_state = ST_R2A;
                end
            end
            ST_R2A: begin
                u_a     = UW'(r_fill);
                u_b     = UW'(r_ch);
                u_c     = UW'(r_atlas_w);
                n_flag  = u_le || (r_ch == '0);
                n_state = ST_R2B;
            end
            ST_R2B: begin
                u_a = UW'(r_closed);
                u_b = UW'(r_cw);
                u_c = UW'(r_cah);
                if (r_flag && (u_le || r_cw == '0)) begin
                    n_cw    = r_ch;
                    n_ch    = r_cw;
                    n_state = ST_PUT1;
                end else begin
                    n_state = ST_ROPEN;
                end
            end
            ST_ROPEN: begin
                u_a       = UW'(r_closed);
                u_b       = UW'(r_shelf_h);
                n_closed  = u_sum[HW-1:0];
                n_fill    = '0;
                n_shelf_h = '0;
                n_state   = ST_RPICK;
            end
            ST_RPICK: begin
                // Long side fits across: lay it down
                u_a = UW'(r_ch);
                u_c = UW'(r_atlas_w);
                if (u_le) begin
                    n_cw = r_ch;
                    n_ch = r_cw;
                end
                n_state = ST_U1;
            end
            ST_U1: begin
                u_a     = UW'(r_fill);
                u_b     = UW'(r_cw);
                u_c     = UW'(r_atlas_w);
                n_state = u_le ? ST_UNEED : ST_UOPEN;
            end
            ST_UOPEN: begin
                u_a       = UW'(r_closed);
                u_b       = UW'(r_shelf_h);
                n_closed  = u_sum[HW-1:0];
                n_fill    = '0;
                n_shelf_h = '0;
                n_state   = ST_UFIT;
            end
            ST_UFIT: begin
                u_a     = UW'(r_cw);
                u_c     = UW'(r_atlas_w);
                n_state = u_le ? ST_UNEED : ST_FIN;
            end
            ST_UNEED: begin
                u_a = UW'(r_closed);
                u_b = UW'(r_ch);
                u_c = UW'(r_cah);
                if (u_le) begin
                    n_state = ST_PUT1;
                end else if (!r_allow_grow || r_cah == '0) begin
                    n_state = ST_FIN;
                end else begin
                    n_g     = UW'(r_cah);
                    n_need  = u_sum[UW-1:0];
                    n_state = ST_GROW;
                end
            end
            ST_GROW: begin
                // Double while below the need and within range
                u_a = r_need;
                u_c = r_g;
                if (!u_le && r_g <= COORD_MAX) begin
                    n_g = {r_g[UW-2:0], 1'b0};
                end else if (r_g > COORD_MAX) begin
                    n_state = ST_FIN;
                end else begin
                    n_cah   = r_g[HW-1:0];
                    n_state = ST_PUT1;
                end
            end
            ST_PUT1: begin
                u_a     = UW'(r_fill);
                u_b     = UW'(r_cw);
                n_rx    = r_fill;
                n_ry    = r_closed;
                n_fill  = u_sum[FIELD_W-1:0];
                n_state = ST_PUT2;
            end
            ST_PUT2: begin
                u_a = UW'(r_ch);
                u_c = UW'(r_shelf_h);
                if (!u_le) begin
                    n_shelf_h = r_ch;
                end
                n_ok    = 1'b1;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (fin_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output register: load on finish, drop on handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_load) begin
            r_out_valid <= 1'b1;
        end else if (o_place.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_load) begin
            r_o_placed <= r_ok;
            r_o_x      <= r_ok ? r_rx : '0;
            r_o_y      <= r_ok ? r_ry[FIELD_W-1:0] : '0;
            r_o_w      <= r_ok ? r_cw : '0;
            r_o_h      <= r_ok ? r_ch : '0;
            r_o_ah     <= r_cah[FIELD_W-1:0];
        end
    end

    assign o_place.valid         = r_out_valid;
    assign o_place.placed        = r_o_placed;
    assign o_place.pos_x         = r_o_x;
    assign o_place.pos_y         = r_o_y;
    assign o_place.stored_width  = r_o_w;
    assign o_place.stored_height = r_o_h;
    assign o_place.atlas_height  = r_o_ah;

    // Closed shelves plus the open shelf never pass the atlas height when idle
    a_height_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |->
            ({1'b0, r_closed} + UW'(r_shelf_h)) <= {1'b0, r_cah})
        else $error("shelf stack exceeds atlas height");

    // Atlas height only grows between resets
    a_height_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_cah >= $past(r_cah))
        else $error("atlas height shrank");

    // An accepted beat starts the sequencer
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rect.valid && i_rect.ready |=> r_state != ST_IDLE)
        else $error("accepted beat left sequencer idle");

    // A rejected result carries no position or size
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_o_placed |->
            r_o_x == '0 && r_o_y == '0 && r_o_w == '0 && r_o_h == '0)
        else $error("rejected result with nonzero placement");

endmodule

`default_nettype wire
